@@ sv/fnvh_pkg.sv @@
// Package for the FNV-1a two-string identifier hash unit.
// Holds beat types, opcode codes, FNV constants and the fold function.
// No dependencies.
package fnvh_pkg;

	// Opcodes of an input beat
	localparam logic [1:0] OP_TYPE   = 2'd0;
	localparam logic [1:0] OP_NAME   = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// FNV-1a 32-bit offset basis, separator byte and reset length limit
	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [7:0]  SEP_BYTE  = 8'h2F;
	localparam logic [7:0]  LIMIT_RST = 8'd64;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] hash_id;
		logic        truncated;
	} out_item_t;

	// Work entry passed from the classifier to the hash datapath
	typedef struct packed {
		logic       do_sep;
		logic       do_byte;
		logic       finish;
		logic       truncated;
		logic [7:0] data_byte;
	} q_entry_t;

	// One FNV-1a step: xor the byte in, multiply by 16777619 (0x01000193)
	// as a shift-add over bits 0, 1, 4, 7, 8 and 24.
	function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
	endfunction

endpackage

@@ sv/fnv1a_two_string_id_hash_unit.sv @@
// FNV-1a 32-bit identifier over type string, '/', name string; one byte per beat.
// Throughput: one input beat per cycle while the QDEPTH-entry work queue has room; the
// separator fold takes a datapath step of its own in each identifier, so an unbroken stream
// stalls the input once the queue has filled.
// Result path: work queue, separator fold if pending, then the output register. Reset: async,
// clears control state, hash to offset basis, length limit (max_len_q) to 64.
module fnv1a_two_string_id_hash_unit
	import fnvh_pkg::*;
#(
	parameter int QDEPTH = 4
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	logic [7:0] max_len_q;
	logic       q_full;
	logic       push;
	q_entry_t   push_entry;
	logic       pop;
	logic       head_valid;
	q_entry_t   head;

	// Hold the length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= LIMIT_RST;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	fnvh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.max_len    (max_len_q),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	fnvh_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	fnvh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule

@@ sv/fnvh_front.sv @@
// Front end of the FNV-1a identifier unit: accepts input beats and classifies them.
// Tracks string counts, end marks, separator and overflow; depends on fnvh_pkg.
// Emits work entries only for beats that change the hash or finish an identifier.
module fnvh_front
	import fnvh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_item,
	input  logic [7:0] max_len,
	input  logic     q_full,
	output logic     push,
	output q_entry_t push_entry
);

	logic [7:0] type_cnt_q, name_cnt_q, type_cnt_d, name_cnt_d;
	logic       sep_q, type_end_q, name_end_q, ovf_q;
	logic       sep_d, type_end_d, name_end_d, ovf_d;
	logic       accept;
	logic       need;
	q_entry_t   ent;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Classify the beat and work out the next control state
	always_comb begin
		type_cnt_d = type_cnt_q;
		name_cnt_d = name_cnt_q;
		sep_d      = sep_q;
		type_end_d = type_end_q;
		name_end_d = name_end_q;
		ovf_d      = ovf_q;
		ent        = '0;
		ent.data_byte = in_item.data_byte;
		unique case (in_item.opcode)
			OP_TYPE: begin
				if (!sep_q && !type_end_q) begin
					if (in_item.data_byte == 8'd0) begin
						type_end_d = 1'b1;
					end else if (type_cnt_q < max_len) begin
						type_cnt_d  = type_cnt_q + 8'd1;
						ent.do_byte = 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
				end
			end
			OP_NAME: begin
				ent.do_sep = !sep_q;
				sep_d      = 1'b1;
				if (!name_end_q) begin
					if (in_item.data_byte == 8'd0) begin
						name_end_d = 1'b1;
					end else if (name_cnt_q < max_len) begin
						name_cnt_d  = name_cnt_q + 8'd1;
						ent.do_byte = 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
				end
			end
			OP_FINISH: begin
				ent.do_sep    = !sep_q;
				ent.finish    = 1'b1;
				ent.truncated = ovf_q;
				type_cnt_d    = 8'd0;
				name_cnt_d    = 8'd0;
				sep_d         = 1'b0;
				type_end_d    = 1'b0;
				name_end_d    = 1'b0;
				ovf_d         = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign need       = ent.do_sep || ent.do_byte || ent.finish;
	assign push       = accept && need;
	assign push_entry = ent;

	// Advance control state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_cnt_q <= 8'd0;
			name_cnt_q <= 8'd0;
			sep_q      <= 1'b0;
			type_end_q <= 1'b0;
			name_end_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (accept) begin
			type_cnt_q <= type_cnt_d;
			name_cnt_q <= name_cnt_d;
			sep_q      <= sep_d;
			type_end_q <= type_end_d;
			name_end_q <= name_end_d;
			ovf_q      <= ovf_d;
		end
	end

endmodule

@@ sv/fnvh_queue.sv @@
// Small work queue between the classifier and the hash datapath.
// Register array with head and tail pointers and a fill count; depends on fnvh_pkg.
module fnvh_queue
	import fnvh_pkg::*;
#(
	parameter int DEPTH = 4
)
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	output logic     full,
	input  logic     pop,
	output logic     head_valid,
	output q_entry_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	q_entry_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT) else $error("queue count out of range");
`endif

endmodule

@@ sv/fnvh_back.sv @@
// FNV-1a hash datapath (depends on fnvh_pkg): folds queued bytes, emits on finish.
// One fold per cycle unless out_stall holds a finish; a separator folds on its own.
module fnvh_back
	import fnvh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  q_entry_t  head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	logic [31:0] h_q;
	logic        sep_phase_q;
	logic        out_valid_q;
	out_item_t   out_item_q;
	logic        out_free;
	logic        sep_step;
	logic        emit;

	assign out_free = !out_valid_q || !out_stall;
	assign sep_step = head_valid && head.do_sep && !sep_phase_q;
	assign emit     = head_valid && !sep_step && head.finish && out_free;
	assign pop      = head_valid && !sep_step && (!head.finish || out_free);

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Fold separator or byte, clear on finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q         <= FNV_BASIS;
			sep_phase_q <= 1'b0;
		end else if (sep_step) begin
			h_q         <= fnv_fold(h_q, SEP_BYTE);
			sep_phase_q <= 1'b1;
		end else if (pop) begin
			sep_phase_q <= 1'b0;
			if (head.finish) begin
				h_q <= FNV_BASIS;
			end else if (head.do_byte) begin
				h_q <= fnv_fold(h_q, head.data_byte);
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_item_q.hash_id   <= h_q;
			out_item_q.truncated <= head.truncated;
		end
	end

`ifndef SYNTHESIS
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q) else $error("finish did not raise out_valid");
	a_basis_after: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> h_q == FNV_BASIS) else $error("hash not cleared after finish");
	a_sep_phase: assert property (@(posedge clk) disable iff (!arst_n)
		sep_phase_q |-> head_valid && head.do_sep) else $error("stray separator phase");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !emit) else $error("result overwritten while held");
`endif

endmodule

@@ test/tb.sv @@
// Testbench for fnv1a_two_string_id_hash_unit: directed and random identifiers checked
// against an FNV-1a predictor held in a small scoreboard class.
// Depends on fnvh_pkg and the unit itself.
module tb;
	import fnvh_pkg::*;

	localparam logic [31:0] ID_PRIME = 32'd16777619;
	localparam int IDLE_PCT = 23;

	// Track expected identifiers and check each result beat against the oldest one
	class fnv_id_scoreboard;
		logic [31:0] id_hash;
		logic [7:0]  str_count [2];
		bit          str_ended [2];
		bit          sep_done;
		bit          overflow;
		logic [7:0]  limit;
		out_item_t   pending_ids[$];
		int          errors;
		int          ids_checked;
		int          ids_truncated;

		function new();
			limit = LIMIT_RST;
			errors = 0;
			ids_checked = 0;
			ids_truncated = 0;
			clear();
		endfunction

		function void clear();
			id_hash = FNV_BASIS;
			str_count[0] = 8'd0;
			str_count[1] = 8'd0;
			str_ended[0] = 1'b0;
			str_ended[1] = 1'b0;
			sep_done = 1'b0;
			overflow = 1'b0;
		endfunction

		function logic [31:0] mix(input logic [31:0] h, input logic [7:0] b);
			return (h ^ {24'd0, b}) * ID_PRIME;
		endfunction

		// Hash one string byte; zero ends the string, bytes past the limit only flag
		function void take_byte(input int s, input logic [7:0] b);
			if (!str_ended[s]) begin
				if (b == 8'h00) begin
					str_ended[s] = 1'b1;
				end else if (str_count[s] < limit) begin
					id_hash = mix(id_hash, b);
					str_count[s] = str_count[s] + 8'd1;
				end else begin
					overflow = 1'b1;
				end
			end
		endfunction

		function void fold_sep();
			if (!sep_done) begin
				id_hash = mix(id_hash, SEP_BYTE);
				sep_done = 1'b1;
			end
		endfunction

		// Advance the prediction by one accepted input beat
		function void note_input(input in_item_t it);
			out_item_t exp_id;
			case (it.opcode)
				OP_TYPE: begin
					if (!sep_done)
						take_byte(0, it.data_byte);
				end
				OP_NAME: begin
					fold_sep();
					take_byte(1, it.data_byte);
				end
				OP_FINISH: begin
					fold_sep();
					exp_id.hash_id = id_hash;
					exp_id.truncated = overflow;
					pending_ids.push_back(exp_id);
					clear();
				end
				default: begin
				end
			endcase
		endfunction

		// Compare one accepted result beat with the oldest expectation
		function void check_result(input out_item_t got);
			out_item_t exp_id;
			if (pending_ids.size() == 0) begin
				$error("unexpected result: hash_id %h truncated %b", got.hash_id, got.truncated);
				errors++;
			end else begin
				exp_id = pending_ids.pop_front();
				ids_checked++;
				if (exp_id.truncated)
					ids_truncated++;
				if (got.hash_id !== exp_id.hash_id) begin
					$error("hash_id: expected %h, got %h", exp_id.hash_id, got.hash_id);
					errors++;
				end
				if (got.truncated !== exp_id.truncated) begin
					$error("truncated: expected %b, got %b", exp_id.truncated, got.truncated);
					errors++;
				end
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;

	fnv_id_scoreboard sb;
	bit calm;
	int beats_sent;
	int settings_used;

	fnv1a_two_string_id_hash_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stall the result side at random, except in calm stretches
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Watch both channels
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_input(in_item);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_item);
	end

	// Drive one input beat and hold it until accepted
	task automatic send_beat(input logic [1:0] op, input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{opcode: op, data_byte: b};
		do @(posedge clk); while (in_stall);
		if (op != OP_UNUSED)
			beats_sent++;
	endtask

	// Drop valid and wait until every expected identifier has come out
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_ids.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.limit = v;
		settings_used++;
	endtask

	function automatic int pick_len();
		if (sb.limit <= 8'd12)
			return $urandom_range(0, sb.limit + 3);
		return $urandom_range(0, 14);
	endfunction

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 99) < 6)
			return 8'h00;
		return 8'($urandom_range(1, 255));
	endfunction

	// Send a well-formed identifier with random content and occasional stray beats
	task automatic send_random_id(input int n_type);
		int n_name;
		n_name = pick_len();
		for (int i = 0; i < n_type; i++) begin
			if ($urandom_range(0, 99) < 4)
				send_beat(OP_UNUSED, 8'($urandom_range(0, 255)));
			send_beat(OP_TYPE, pick_byte());
		end
		for (int i = 0; i < n_name; i++) begin
			if ($urandom_range(0, 99) < 5)
				send_beat(OP_TYPE, 8'($urandom_range(0, 255)));
			send_beat(OP_NAME, pick_byte());
		end
		send_beat(OP_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// Send a short run of arbitrary beats closed by a finish
	task automatic send_noise_id();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
		send_beat(OP_FINISH, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		logic [7:0] phase_limits [8];
		int phase_goal;
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'd0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		calm = 1'b0;
		beats_sent = 0;
		settings_used = 1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: plain identifier at the reset limit
		send_beat(OP_TYPE, 8'h61);
		send_beat(OP_NAME, 8'h62);
		send_beat(OP_FINISH, 8'h00);
		// Finish with no strings folds the separator alone
		send_beat(OP_FINISH, 8'hFF);
		// Zero ends the type string, unused opcode, zero as first name byte
		send_beat(OP_TYPE, 8'hFF);
		send_beat(OP_TYPE, 8'h00);
		send_beat(OP_TYPE, 8'h41);
		send_beat(OP_UNUSED, 8'hFF);
		send_beat(OP_NAME, 8'h00);
		send_beat(OP_NAME, 8'h7F);
		send_beat(OP_FINISH, 8'h00);
		// Type byte after the name started is ignored
		send_beat(OP_NAME, 8'h80);
		send_beat(OP_TYPE, 8'h01);
		send_beat(OP_NAME, 8'h01);
		send_beat(OP_FINISH, 8'h00);
		// Limit of one truncates the second type byte
		write_limit(8'd1);
		send_beat(OP_TYPE, 8'h55);
		send_beat(OP_TYPE, 8'hAA);
		send_beat(OP_NAME, 8'h00);
		send_beat(OP_FINISH, 8'h00);
		// Limit of zero truncates any non-zero byte
		write_limit(8'd0);
		send_beat(OP_TYPE, 8'h10);
		send_beat(OP_NAME, 8'h33);
		send_beat(OP_FINISH, 8'h00);
		write_limit(8'd255);
		send_beat(OP_TYPE, 8'h2F);
		send_beat(OP_NAME, 8'hFE);
		send_beat(OP_FINISH, 8'h00);

		// Random phases, each under its own limit
		phase_limits = '{8'd64, 8'd2, 8'd255, 8'd1, 8'd7, 8'd0, 8'd30, 8'd255};
		phase_limits[7] = 8'($urandom_range(1, 255));
		for (int p = 0; p < 8; p++) begin
			write_limit(phase_limits[p]);
			calm = (p == 2);
			phase_goal = beats_sent + 30;
			// One long type string right past the top limit
			if (p == 2)
				send_random_id(256);
			while (beats_sent < phase_goal) begin
				if ($urandom_range(0, 99) < 10)
					send_noise_id();
				else
					send_random_id(pick_len());
			end
		end
		calm = 1'b0;

		settle();
		repeat (10) @(posedge clk);
		$display("checked %0d identifiers (%0d truncated) from %0d input beats",
			sb.ids_checked, sb.ids_truncated, beats_sent);
		$display("used %0d limit settings, random idling on both channels", settings_used);
		if (sb.errors == 0 && sb.pending_ids.size() == 0) begin
			$display("status: pass");
		end else begin
			if (sb.pending_ids.size() != 0)
				$error("%0d expected identifiers never arrived", sb.pending_ids.size());
			$display("status: fail");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

endmodule
